>>> rtl/ses_pkg.sv
// Shared types, constants and lookup functions of the encoder setpoint editor.
// Used by the channel interfaces and by the top level. No dependencies.
package ses_pkg;

    // Field widths
    localparam int VOLT_W     = 17;
    localparam int AMP_W      = 14;
    localparam int DET_W      = 5;
    localparam int CELL_W     = 3;
    localparam int DIGITS_W   = 20;
    localparam int MASK_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int VDIG_W     = 3;
    localparam int ADIG_W     = 2;

    // Number of BCD places in the converted value
    localparam int PLACES = 5;

    // Display limits and reset values
    localparam logic [VOLT_W-1:0] VOLT_MAX_SHOWN = 17'd99999;
    localparam logic [AMP_W-1:0]  AMP_MAX_SHOWN  = 14'd9999;
    localparam logic [VOLT_W-1:0] VOLT_LIMIT_RST = 17'd30000;
    localparam logic [AMP_W-1:0]  AMP_LIMIT_RST  = 14'd5000;
    localparam logic [VOLT_W-1:0] VOLT_SET_RST   = 17'd12000;
    localparam logic [AMP_W-1:0]  AMP_SET_RST    = 14'd1500;

    // Last selectable voltage digit (units of millivolts)
    localparam logic [VDIG_W-1:0] VOLT_DIG_LAST = 3'd4;

    // Full-redraw masks, point cell included
    localparam logic [MASK_W-1:0] MASK_VOLT_ALL = 6'h3F;
    localparam logic [MASK_W-1:0] MASK_AMP_ALL  = 6'h1F;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_LIMIT  = 1'b1;

    // Event codes; code 3 is unused and does nothing
    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_DIGIT  = 2'd1,
        OP_TURN   = 2'd2
    } op_t;

    // Weight of BCD place k, k = 0 is units
    localparam int unsigned PLACE_WEIGHT [PLACES] = '{1, 10, 100, 1000, 10000};

    // Display cell of BCD place k
    localparam logic [CELL_W-1:0] VOLT_PLACE_CELL [PLACES] =
        '{3'd5, 3'd4, 3'd3, 3'd1, 3'd0};
    localparam logic [CELL_W-1:0] AMP_PLACE_CELL [PLACES-1] =
        '{3'd4, 3'd3, 3'd2, 3'd0};

    // One item travelling down the conversion pipeline
    typedef struct packed {
        logic                  live_field;
        logic [CELL_W-1:0]     digit_cell;
        logic [VOLT_W-1:0]     volt;
        logic [AMP_W-1:0]      amp;
        logic                  is_amp;
        logic                  is_turn;
        logic [MASK_W-1:0]     mask_pre;
        logic                  redraw;
        logic [VOLT_W-1:0]     old_rem;
        logic [VOLT_W-1:0]     new_rem;
        logic [DIGITS_W-1:0]   old_bcd;
        logic [DIGITS_W-1:0]   new_bcd;
    } pipe_t;

    // Step weight of the selected voltage digit
    function automatic logic [AMP_W-1:0] volt_weight(input logic [VDIG_W-1:0] d);
        case (d)
            3'd0:    return 14'd10000;
            3'd1:    return 14'd1000;
            3'd2:    return 14'd100;
            3'd3:    return 14'd10;
            default: return 14'd1;
        endcase
    endfunction

    // Display cell of the selected voltage digit
    function automatic logic [CELL_W-1:0] volt_cell(input logic [VDIG_W-1:0] d);
        case (d)
            3'd0:    return 3'd0;
            3'd1:    return 3'd1;
            3'd2:    return 3'd3;
            3'd3:    return 3'd4;
            default: return 3'd5;
        endcase
    endfunction

    // Step weight of the selected current digit
    function automatic logic [AMP_W-1:0] amp_weight(input logic [ADIG_W-1:0] d);
        case (d)
            2'd0:    return 14'd1000;
            2'd1:    return 14'd100;
            2'd2:    return 14'd10;
            default: return 14'd1;
        endcase
    endfunction

    // Display cell of the selected current digit
    function automatic logic [CELL_W-1:0] amp_cell(input logic [ADIG_W-1:0] d);
        case (d)
            2'd0:    return 3'd0;
            2'd1:    return 3'd2;
            2'd2:    return 3'd3;
            default: return 3'd4;
        endcase
    endfunction

endpackage

>>> rtl/ses_if.sv
// Valid/ready channel interfaces of the encoder setpoint editor.
// Depends on ses_pkg for the field widths.
interface ses_cmd_if;
    import ses_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic signed [DET_W-1:0] detents;

    modport source (output valid, op, detents, input ready);
    modport sink   (input valid, op, detents, output ready);
endinterface

interface ses_rsp_if;
    import ses_pkg::*;

    logic                valid;
    logic                ready;
    logic                live_field;
    logic [CELL_W-1:0]   digit_cell;
    logic [VOLT_W-1:0]   volt_value;
    logic [AMP_W-1:0]    amp_value;
    logic [DIGITS_W-1:0] live_digits;
    logic [MASK_W-1:0]   cell_mask;
    logic                full_redraw;

    modport source (output valid, live_field, digit_cell, volt_value, amp_value,
                     live_digits, cell_mask, full_redraw, input ready);
    modport sink   (input valid, live_field, digit_cell, volt_value, amp_value,
                     live_digits, cell_mask, full_redraw, output ready);
endinterface

>>> rtl/encoder_setpoint_editor.sv
// Encoder setpoint editor: voltage/current setpoints edited by select, digit and turn items.
// Depends on ses_pkg and on the ses_cmd_if / ses_rsp_if channel interfaces.
//
// The block takes one item per clock while the output side is not stalled, and
// returns one result per item, in order of acceptance. The setpoint,
// live-field and digit registers are updated in the cycle the item is accepted,
// so back-to-back items always see the effect of the one before. The decimal
// split of the live value then runs through four pipeline stages, one BCD place
// each, and the changed-cell mask is formed in the result register. A stall on
// the result channel freezes the whole pipeline and drops cmd.ready. Limits are
// written through cfg_we/cfg_index/cfg_data; a limit above the display range acts
// as the display maximum, and a setpoint above a lowered limit stays until a turn.
module encoder_setpoint_editor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ses_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ses_pkg::CFG_DATA_W-1:0]     cfg_data,
    ses_cmd_if.sink                            cmd,
    ses_rsp_if.source                          rsp
);
    import ses_pkg::*;

    localparam int STAGES = PLACES - 1;

    // Configuration
    logic [VOLT_W-1:0] volt_limit_reg;
    logic [AMP_W-1:0]  amp_limit_reg;

    // Editor state
    logic              active_reg, active_next;
    logic [VOLT_W-1:0] volt_set_reg, volt_set_next;
    logic [AMP_W-1:0]  amp_set_reg, amp_set_next;
    logic [VDIG_W-1:0] volt_dig_reg, volt_dig_next;
    logic [ADIG_W-1:0] amp_dig_reg, amp_dig_next;

    // Pipeline
    logic              en;
    logic              take;
    pipe_t             upd_next;
    pipe_t             stage_reg [STAGES+1];
    pipe_t             step_next [STAGES];
    logic              valid_reg [STAGES+1];

    // Result register
    logic                out_valid_reg;
    logic                out_field_reg;
    logic [CELL_W-1:0]   out_cell_reg;
    logic [VOLT_W-1:0]   out_volt_reg;
    logic [AMP_W-1:0]    out_amp_reg;
    logic [DIGITS_W-1:0] out_digits_reg, out_digits_next;
    logic [MASK_W-1:0]   out_mask_reg, out_mask_next;
    logic                out_redraw_reg;

    // Turn arithmetic
    logic [VOLT_W-1:0]   cur;
    logic [VOLT_W-1:0]   lim_eff;
    logic [AMP_W-1:0]    weight;
    logic signed [14:0]  weight_s;
    logic signed [19:0]  prod;
    logic signed [20:0]  sum;
    logic [VOLT_W-1:0]   clamped;
    logic                moved;
    logic [ADIG_W-1:0]   amp_dig_inc;

    // Whole pipeline moves when the result register is free or being taken
    assign en        = !out_valid_reg || rsp.ready;
    assign cmd.ready = en;
    assign take      = cmd.valid && en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_limit_reg <= VOLT_LIMIT_RST;
            amp_limit_reg  <= AMP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOLT_LIMIT: volt_limit_reg <= cfg_data[VOLT_W-1:0];
                CFG_AMP_LIMIT:  amp_limit_reg  <= cfg_data[AMP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Turn: value plus weight times detents, clamped to zero and the limit
    always_comb
    begin
        if (active_reg)
        begin
            cur    = VOLT_W'(amp_set_reg);
            weight = amp_weight(amp_dig_reg);
            lim_eff = (amp_limit_reg > AMP_MAX_SHOWN) ? VOLT_W'(AMP_MAX_SHOWN)
                                                      : VOLT_W'(amp_limit_reg);
        end
        else
        begin
            cur    = volt_set_reg;
            weight = volt_weight(volt_dig_reg);
            lim_eff = (volt_limit_reg > VOLT_MAX_SHOWN) ? VOLT_MAX_SHOWN : volt_limit_reg;
        end
        weight_s = signed'({1'b0, weight});
        prod     = 20'(weight_s) * 20'(cmd.detents);
        sum      = signed'(21'({4'b0, cur})) + 21'(prod);
        if (sum < 0)
            clamped = '0;
        else if (sum > signed'(21'({4'b0, lim_eff})))
            clamped = lim_eff;
        else
            clamped = sum[VOLT_W-1:0];
        moved = clamped != cur;
    end

    assign amp_dig_inc = amp_dig_reg + 2'd1;

    // Event decode and next state
    always_comb
    begin
        active_next   = active_reg;
        volt_set_next = volt_set_reg;
        amp_set_next  = amp_set_reg;
        volt_dig_next = volt_dig_reg;
        amp_dig_next  = amp_dig_reg;
        upd_next      = '0;

        case (cmd.op)
            OP_SELECT:
            begin
                active_next       = !active_reg;
                upd_next.mask_pre = active_reg ? MASK_VOLT_ALL : MASK_AMP_ALL;
                upd_next.redraw   = 1'b1;
            end
            OP_DIGIT:
            begin
                if (active_reg)
                begin
                    amp_dig_next      = amp_dig_inc;
                    upd_next.mask_pre = (MASK_W'(1) << amp_cell(amp_dig_reg))
                                      | (MASK_W'(1) << amp_cell(amp_dig_inc));
                end
                else
                begin
                    volt_dig_next = (volt_dig_reg >= VOLT_DIG_LAST) ? '0
                                                                     : volt_dig_reg + 3'd1;
                    upd_next.mask_pre = (MASK_W'(1) << volt_cell(volt_dig_reg))
                                      | (MASK_W'(1) << volt_cell(volt_dig_next));
                end
            end
            OP_TURN:
            begin
                if (moved)
                begin
                    upd_next.is_turn = 1'b1;
                    if (active_reg)
                        amp_set_next = clamped[AMP_W-1:0];
                    else
                        volt_set_next = clamped;
                end
            end
            default: ;
        endcase

        upd_next.live_field = active_next;
        upd_next.digit_cell = active_next ? amp_cell(amp_dig_next) : volt_cell(volt_dig_next);
        upd_next.volt       = volt_set_next;
        upd_next.amp        = amp_set_next;
        upd_next.is_amp     = active_next;
        upd_next.new_rem    = active_next ? VOLT_W'(amp_set_next) : volt_set_next;
        upd_next.old_rem    = upd_next.is_turn ? cur : upd_next.new_rem;
    end

    // State registers, updated as each item is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            volt_set_reg <= VOLT_SET_RST;
            amp_set_reg  <= AMP_SET_RST;
            volt_dig_reg <= '0;
            amp_dig_reg  <= '0;
        end
        else if (take)
        begin
            active_reg   <= active_next;
            volt_set_reg <= volt_set_next;
            amp_set_reg  <= amp_set_next;
            volt_dig_reg <= volt_dig_next;
            amp_dig_reg  <= amp_dig_next;
        end
    end

    // First pipeline register
    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg[0] <= upd_next;
    end

    // Valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= take;
            for (int i = 1; i <= STAGES; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // One BCD place per stage, most significant first
    for (genvar k = 0; k < STAGES; k++)
    begin : g_place
        localparam int PLACE = PLACES - 1 - k;
        localparam int unsigned WEIGHT = PLACE_WEIGHT[PLACE];

        always_comb
        begin
            logic [3:0]        od, nd;
            logic [VOLT_W-1:0] orem, nrem;
            od   = '0;
            nd   = '0;
            orem = stage_reg[k].old_rem;
            nrem = stage_reg[k].new_rem;
            // parallel compares against the multiples of the place weight
            for (int j = 1; j < 10; j++)
            begin
                if (stage_reg[k].old_rem >= VOLT_W'(WEIGHT * j))
                begin
                    od   = 4'(j);
                    orem = stage_reg[k].old_rem - VOLT_W'(WEIGHT * j);
                end
                if (stage_reg[k].new_rem >= VOLT_W'(WEIGHT * j))
                begin
                    nd   = 4'(j);
                    nrem = stage_reg[k].new_rem - VOLT_W'(WEIGHT * j);
                end
            end
            step_next[k]                      = stage_reg[k];
            step_next[k].old_rem              = orem;
            step_next[k].new_rem              = nrem;
            step_next[k].old_bcd[4*PLACE +: 4] = od;
            step_next[k].new_bcd[4*PLACE +: 4] = nd;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stage_reg[k+1] <= step_next[k];
        end
    end

    // Units place, then changed-cell mask for turns
    always_comb
    begin
        logic [DIGITS_W-1:0] old_full;
        old_full        = stage_reg[STAGES].old_bcd;
        out_digits_next = stage_reg[STAGES].new_bcd;
        old_full[3:0]        = stage_reg[STAGES].old_rem[3:0];
        out_digits_next[3:0] = stage_reg[STAGES].new_rem[3:0];
        out_mask_next = stage_reg[STAGES].mask_pre;
        if (stage_reg[STAGES].is_turn)
        begin
            out_mask_next = '0;
            for (int p = 0; p < PLACES; p++)
            begin
                if (old_full[4*p +: 4] != out_digits_next[4*p +: 4])
                begin
                    if (!stage_reg[STAGES].is_amp)
                        out_mask_next[VOLT_PLACE_CELL[p]] = 1'b1;
                    else if (p < PLACES - 1)
                        out_mask_next[AMP_PLACE_CELL[p]] = 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_field_reg  <= stage_reg[STAGES].live_field;
            out_cell_reg   <= stage_reg[STAGES].digit_cell;
            out_volt_reg   <= stage_reg[STAGES].volt;
            out_amp_reg    <= stage_reg[STAGES].amp;
            out_digits_reg <= out_digits_next;
            out_mask_reg   <= out_mask_next;
            out_redraw_reg <= stage_reg[STAGES].redraw;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.live_field  = out_field_reg;
    assign rsp.digit_cell  = out_cell_reg;
    assign rsp.volt_value  = out_volt_reg;
    assign rsp.amp_value   = out_amp_reg;
    assign rsp.live_digits = out_digits_reg;
    assign rsp.cell_mask   = out_mask_reg;
    assign rsp.full_redraw = out_redraw_reg;

    // Checks
    a_select_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cmd.op == OP_SELECT) |=> active_reg != $past(active_reg))
        else $error("select item did not toggle the live setpoint");

    a_setpoints_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (volt_set_reg <= VOLT_MAX_SHOWN) && (amp_set_reg <= AMP_MAX_SHOWN))
        else $error("setpoint beyond display range");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        volt_dig_reg <= VOLT_DIG_LAST)
        else $error("voltage digit selection out of range");

    a_redraw_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.full_redraw |->
            (rsp.cell_mask == MASK_VOLT_ALL) || (rsp.cell_mask == MASK_AMP_ALL))
        else $error("full redraw without a full cell mask");

endmodule

>>> tb/sv/encoder_setpoint_editor_test.sv
// Self-checking bench for encoder_setpoint_editor: directed and random panel items,
// checked against a cycle-free model of the setpoints, digit selection and cell mask.
// Depends on ses_pkg, the ses_cmd_if / ses_rsp_if interfaces and the block itself.
module encoder_setpoint_editor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ses_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 12;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef struct packed {
        logic                live_field;
        logic [CELL_W-1:0]   digit_cell;
        logic [VOLT_W-1:0]   volt_value;
        logic [AMP_W-1:0]    amp_value;
        logic [DIGITS_W-1:0] live_digits;
        logic [MASK_W-1:0]   cell_mask;
        logic                full_redraw;
    } panel_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    cycle_count;

    ses_cmd_if cmd_ch ();
    ses_rsp_if rsp_ch ();

    encoder_setpoint_editor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // Step size of each selectable digit
    function automatic int volt_step(input logic [VDIG_W-1:0] d);
        case (d)
            3'd0:    return 10000;
            3'd1:    return 1000;
            3'd2:    return 100;
            3'd3:    return 10;
            default: return 1;
        endcase
    endfunction

    function automatic int amp_step(input logic [ADIG_W-1:0] d);
        case (d)
            2'd0:    return 1000;
            2'd1:    return 100;
            2'd2:    return 10;
            default: return 1;
        endcase
    endfunction

    // Display cell of each selectable digit (point cell skipped)
    function automatic logic [CELL_W-1:0] volt_digit_cell(input logic [VDIG_W-1:0] d);
        case (d)
            3'd0:    return 3'd0;
            3'd1:    return 3'd1;
            3'd2:    return 3'd3;
            3'd3:    return 3'd4;
            default: return 3'd5;
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] amp_digit_cell(input logic [ADIG_W-1:0] d);
        case (d)
            2'd0:    return 3'd0;
            2'd1:    return 3'd2;
            2'd2:    return 3'd3;
            default: return 3'd4;
        endcase
    endfunction

    // Display cell holding decimal place k (k = 0 is units)
    function automatic int place_cell(input logic amps, input int k);
        if (amps)
        begin
            case (k)
                0:       return 4;
                1:       return 3;
                2:       return 2;
                default: return 0;
            endcase
        end
        case (k)
            0:       return 5;
            1:       return 4;
            2:       return 3;
            3:       return 1;
            default: return 0;
        endcase
    endfunction

    // Five BCD nibbles, units in the lowest nibble
    function automatic logic [DIGITS_W-1:0] to_decimal(input int unsigned v);
        logic [DIGITS_W-1:0] r;
        r = '0;
        for (int k = 0; k < PLACES; k++)
        begin
            r[4*k +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    // Panel state plus the queue of results still owed by the block
    class setpoint_tracker;
        logic                  live_amp;
        logic [VOLT_W-1:0]     volt_sp;
        logic [AMP_W-1:0]      amp_sp;
        logic [VDIG_W-1:0]     vdig;
        logic [ADIG_W-1:0]     adig;
        logic [VOLT_W-1:0]     volt_lim;
        logic [AMP_W-1:0]      amp_lim;
        panel_result_t         pending_results[$];
        int                    error_count;

        function new();
            live_amp    = 1'b0;
            volt_sp     = VOLT_SET_RST;
            amp_sp      = AMP_SET_RST;
            vdig        = '0;
            adig        = '0;
            volt_lim    = VOLT_LIMIT_RST;
            amp_lim     = AMP_LIMIT_RST;
            error_count = 0;
        endfunction

        function void set_limit(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_VOLT_LIMIT)
                volt_lim = val[VOLT_W-1:0];
            else
                amp_lim = val[AMP_W-1:0];
        endfunction

        // Apply one accepted item and queue the result it must produce
        function void note_event(input logic [1:0] op, input logic signed [DET_W-1:0] det);
            panel_result_t want;
            logic [MASK_W-1:0] mask;
            logic [DIGITS_W-1:0] old_bcd;
            logic [DIGITS_W-1:0] new_bcd;
            logic redraw;
            int cur;
            int lim;
            int v;

            mask   = '0;
            redraw = 1'b0;
            case (op)
                OP_SELECT:
                begin
                    live_amp = !live_amp;
                    mask     = live_amp ? MASK_AMP_ALL : MASK_VOLT_ALL;
                    redraw   = 1'b1;
                end
                OP_DIGIT:
                begin
                    if (live_amp)
                    begin
                        mask = MASK_W'(1) << amp_digit_cell(adig);
                        adig = adig + 1'b1;
                        mask |= MASK_W'(1) << amp_digit_cell(adig);
                    end
                    else
                    begin
                        mask = MASK_W'(1) << volt_digit_cell(vdig);
                        vdig = (vdig == VOLT_DIG_LAST) ? '0 : vdig + 1'b1;
                        mask |= MASK_W'(1) << volt_digit_cell(vdig);
                    end
                end
                OP_TURN:
                begin
                    // limits beyond the display range act as the display maximum
                    if (live_amp)
                    begin
                        cur = int'(amp_sp);
                        lim = (amp_lim > AMP_MAX_SHOWN) ? int'(AMP_MAX_SHOWN) : int'(amp_lim);
                        v   = cur + amp_step(adig) * int'(det);
                    end
                    else
                    begin
                        cur = int'(volt_sp);
                        lim = (volt_lim > VOLT_MAX_SHOWN) ? int'(VOLT_MAX_SHOWN)
                                                          : int'(volt_lim);
                        v   = cur + volt_step(vdig) * int'(det);
                    end
                    if (v < 0)
                        v = 0;
                    else if (v > lim)
                        v = lim;
                    // only digits that actually change get marked
                    if (v != cur)
                    begin
                        old_bcd = to_decimal(cur);
                        new_bcd = to_decimal(v);
                        for (int k = 0; k < (live_amp ? PLACES - 1 : PLACES); k++)
                            if (old_bcd[4*k +: 4] != new_bcd[4*k +: 4])
                                mask |= MASK_W'(1) << place_cell(live_amp, k);
                        if (live_amp)
                            amp_sp = AMP_W'(v);
                        else
                            volt_sp = VOLT_W'(v);
                    end
                end
                default: ;
            endcase

            want.live_field  = live_amp;
            want.digit_cell  = live_amp ? amp_digit_cell(adig) : volt_digit_cell(vdig);
            want.volt_value  = volt_sp;
            want.amp_value   = amp_sp;
            want.live_digits = to_decimal(live_amp ? int'(amp_sp) : int'(volt_sp));
            want.cell_mask   = mask;
            want.full_redraw = redraw;
            pending_results.push_back(want);
        endfunction

        function void check_field(input string name, input longint want, input longint got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        // Compare one accepted result with the oldest owed result
        function void check_result(input panel_result_t got);
            panel_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("live_field",  want.live_field,  got.live_field);
            check_field("digit_cell",  want.digit_cell,  got.digit_cell);
            check_field("volt_value",  want.volt_value,  got.volt_value);
            check_field("amp_value",   want.amp_value,   got.amp_value);
            check_field("live_digits", want.live_digits, got.live_digits);
            check_field("cell_mask",   want.cell_mask,   got.cell_mask);
            check_field("full_redraw", want.full_redraw, got.full_redraw);
        endfunction
    endclass

    setpoint_tracker tracker;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);

    // Monitor: results first, then accepted items and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result('{rsp_ch.live_field, rsp_ch.digit_cell,
                                       rsp_ch.volt_value, rsp_ch.amp_value,
                                       rsp_ch.live_digits, rsp_ch.cell_mask,
                                       rsp_ch.full_redraw});
            if (cmd_ch.valid && cmd_ch.ready)
                tracker.note_event(cmd_ch.op, cmd_ch.detents);
            if (cfg_we)
                tracker.set_limit(cfg_index, cfg_data);
        end
    end

    // Present one item, with random gaps first; entered and left at a falling edge
    task automatic send_event(input logic [1:0] op, input logic signed [DET_W-1:0] det);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid   = 1'b1;
        cmd_ch.op      = op;
        cmd_ch.detents = det;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Stop sending and let every owed result come back
    task automatic wait_idle();
        cmd_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Both limit registers, written only with the block idle
    task automatic apply_limits(input logic [CFG_DATA_W-1:0] volt,
                                input logic [CFG_DATA_W-1:0] amp);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_index = CFG_VOLT_LIMIT;
        cfg_data  = volt;
        @(negedge clk);
        cfg_index = CFG_AMP_LIMIT;
        cfg_data  = amp;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random panel activity, mostly turns, with gentle and wild detent counts
    task automatic run_random(input int count);
        int r;
        logic [1:0] op;
        logic signed [DET_W-1:0] det;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 12)
                op = OP_SELECT;
            else if (r < 32)
                op = OP_DIGIT;
            else if (r < 92)
                op = OP_TURN;
            else
                op = OP_UNUSED;
            if ($urandom_range(1, 0) != 0)
                det = DET_W'(int'($urandom_range(4, 0)) - 2);
            else
                det = DET_W'($urandom_range(31, 0));
            send_event(op, det);
        end
    endtask

    // Stimulus
    initial
    begin
        tracker        = new();
        cycle_count    = 0;
        send_idle_pct  = 28;
        recv_idle_pct  = 54;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_VOLT_LIMIT;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.op      = OP_SELECT;
        cmd_ch.detents = '0;
        rsp_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, clamping both ways, digit wrap, both setpoints
        send_event(OP_UNUSED, 5'sd0);
        send_event(OP_TURN, 5'sd15);
        send_event(OP_TURN, -5'sd16);
        send_event(OP_TURN, -5'sd1);
        send_event(OP_DIGIT, -5'sd16);
        send_event(OP_TURN, 5'sd7);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_TURN, 5'sd5);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_TURN, -5'sd3);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_TURN, 5'sd15);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_SELECT, 5'sd15);
        send_event(OP_TURN, 5'sd15);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_TURN, -5'sd16);
        send_event(OP_DIGIT, 5'sd0);
        send_event(OP_SELECT, 5'sd0);

        // Lowered limits leave the setpoints high until a zero-detent turn clamps them
        apply_limits(VOLT_MAX_SHOWN, CFG_DATA_W'(AMP_MAX_SHOWN));
        send_event(OP_TURN, 5'sd15);
        apply_limits(17'd500, 17'd50);
        send_event(OP_TURN, 5'sd0);
        send_event(OP_SELECT, 5'sd0);
        send_event(OP_TURN, 5'sd0);

        // Sender idles lightly, receiver heavily
        apply_limits('0, '0);
        run_random(150);
        apply_limits(VOLT_MAX_SHOWN, CFG_DATA_W'(AMP_MAX_SHOWN));
        run_random(160);

        // Roles swapped; all-ones limits sit above the display range
        send_idle_pct = 54;
        recv_idle_pct = 28;
        apply_limits(17'h1FFFF, 17'h1FFFF);
        run_random(160);
        apply_limits(CFG_DATA_W'($urandom_range(99999, 0)),
                     CFG_DATA_W'($urandom_range(9999, 0)));
        run_random(160);

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_limits(VOLT_LIMIT_RST, CFG_DATA_W'(AMP_LIMIT_RST));
        run_random(160);
        apply_limits(CFG_DATA_W'($urandom_range(131071, 0)),
                     CFG_DATA_W'($urandom_range(16383, 0)));
        run_random(150);

        wait_idle();
        if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> encoder_setpoint_editor.f
rtl/ses_pkg.sv
rtl/ses_if.sv
rtl/encoder_setpoint_editor.sv
tb/sv/encoder_setpoint_editor_test.sv
